>>> rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared sizes, codes and types for the sorted minimum-price queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int TAG_BITS   = 16;
  localparam int PRICE_BITS = 20;
  localparam int SUM_BITS   = 24;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ERR_W      = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [PRICE_BITS-1:0] price;
  } entry_t;

endpackage

>>> rtl/smpq_store.sv
// ----------------------------------------------------------------------------
// smpq_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module smpq_store
  import smpq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/sorted_min_price_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_min_price_queue_top
// Sorted priority queue of tagged entries, ascending price, with running sum.
// ----------------------------------------------------------------------------
// Insert: entries are read from the tail down; each that sorts above the new
// entry moves up one slot, then the new entry is written (at once if empty).
// Remove: each later entry moves down one slot; a dropped or refused beat
// goes straight to the result. One beat at a time: in_stall holds until the
// result is loaded; the single read port of the entry store sets the pace.
// Reset clears count, sum, state and out_valid; store contents stay undefined.
// ----------------------------------------------------------------------------
module sorted_min_price_queue_top
  import smpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  logic [PRICE_BITS-1:0] in_price,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TAG_BITS-1:0]   out_head_tag,
  output logic [PRICE_BITS-1:0] out_head_price,
  output logic [CNT_W-1:0]      out_count,
  output logic [SUM_BITS-1:0]   out_sum_total,
  output logic                  out_empty_res,
  output logic [ERR_W-1:0]      out_error
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_RD  = 3'd1;
  localparam logic [2:0] ST_INS_CMP = 3'd2;
  localparam logic [2:0] ST_INS_PUT = 3'd3;
  localparam logic [2:0] ST_REM_RD  = 3'd4;
  localparam logic [2:0] ST_REM_WR  = 3'd5;
  localparam logic [2:0] ST_FIN     = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_BITS-1:0] sum_r, sum_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;
  entry_t              new_r, new_nxt;
  entry_t              head_r, head_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  logic [TAG_BITS-1:0]   out_tag_r;
  logic [PRICE_BITS-1:0] out_price_r;
  logic [CNT_W-1:0]      out_count_r;
  logic [SUM_BITS-1:0]   out_sum_r;
  logic                  out_empty_r;
  logic [ERR_W-1:0]      out_err_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic [IDX_W-1:0] mem_ra;
  entry_t           mem_rd;
  logic             moves;
  logic [CNT_W-1:0] idx_ext;

  smpq_store u_store (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign idx_ext = CNT_W'(idx_r);
  assign moves   = (idx_r == '0) ? (mem_rd.price > new_r.price)
                                 : (mem_rd.price >= new_r.price);
  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    new_nxt   = new_r;
    head_nxt  = head_r;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = mem_rd;
    mem_ra    = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          new_nxt.tag   = in_tag;
          new_nxt.price = in_price;
          err_nxt       = ERR_NONE;
          if (in_func == FUNC_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              err_nxt   = ERR_FULL;
              state_nxt = ST_FIN;
            end else if (count_r == '0) begin
              idx_nxt   = '0;
              state_nxt = ST_INS_PUT;
            end else begin
              idx_nxt   = IDX_W'(count_r - CNT_W'(1));
              state_nxt = ST_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              err_nxt   = ERR_EMPTY;
              state_nxt = ST_FIN;
            end else begin
              sum_nxt   = sum_r - SUM_BITS'(head_r.price);
              count_nxt = count_r - CNT_W'(1);
              idx_nxt   = '0;
              state_nxt = (count_r == CNT_W'(1)) ? ST_FIN : ST_REM_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        mem_ra    = idx_r;
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (moves) begin
          mem_we = 1'b1;
          mem_wa = idx_r + IDX_W'(1);
          mem_wd = mem_rd;
          if (idx_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_INS_RD;
          end
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = new_r;
        count_nxt = count_r + CNT_W'(1);
        sum_nxt   = sum_r + SUM_BITS'(new_r.price);
        if (idx_r == '0) begin
          head_nxt = new_r;
        end
        state_nxt = ST_FIN;
      end
      ST_REM_RD: begin
        mem_ra    = idx_r + IDX_W'(1);
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = mem_rd;
        if (idx_r == '0) begin
          head_nxt = mem_rd;
        end
        if (idx_ext + CNT_W'(1) == count_r) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_REM_RD;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    err_r  <= err_nxt;
    new_r  <= new_nxt;
    head_r <= head_nxt;
    if (out_load) begin
      out_tag_r   <= (count_r == '0) ? '0 : head_r.tag;
      out_price_r <= (count_r == '0) ? '0 : head_r.price;
      out_count_r <= count_r;
      out_sum_r   <= sum_r;
      out_empty_r <= (count_r == '0);
      out_err_r   <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_head_tag   = out_tag_r;
  assign out_head_price = out_price_r;
  assign out_count      = out_count_r;
  assign out_sum_total  = out_sum_r;
  assign out_empty_res  = out_empty_r;
  assign out_error      = out_err_r;

endmodule

>>> bench/sorted_min_price_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_min_price_queue_top_tb
// Drives insert and remove orders into the sorted price queue and checks
// every reported head, count, total, empty flag and error code against a
// local model of the sorted store. A short directed table covers the empty
// and full cases, equal prices and the field extremes. Random orders follow,
// in bursts that fill and drain the queue, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module sorted_min_price_queue_top_tb;
  import smpq_pkg::*;

  typedef struct packed {
    logic [TAG_BITS-1:0]   head_tag;
    logic [PRICE_BITS-1:0] head_price;
    logic [CNT_W-1:0]      count;
    logic [SUM_BITS-1:0]   sum_total;
    logic                  empty_res;
    logic [ERR_W-1:0]      error;
  } queue_report_t;

  typedef struct {
    logic                  func;
    logic [TAG_BITS-1:0]   tag;
    logic [PRICE_BITS-1:0] price;
    bit                    typed;
    queue_report_t         want;
  } order_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_func;
  logic [TAG_BITS-1:0]   in_tag;
  logic [PRICE_BITS-1:0] in_price;
  logic                  out_valid;
  logic                  out_stall;
  logic [TAG_BITS-1:0]   out_head_tag;
  logic [PRICE_BITS-1:0] out_head_price;
  logic [CNT_W-1:0]      out_count;
  logic [SUM_BITS-1:0]   out_sum_total;
  logic                  out_empty_res;
  logic [ERR_W-1:0]      out_error;

  entry_t                book [CAPACITY];
  int                    held;
  logic [SUM_BITS-1:0]   book_sum;
  queue_report_t         reports_due [$];
  order_row_t            plan [$];
  int                    gap_pct;
  int                    stall_pct;
  int                    failures;

  sorted_min_price_queue_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_tag         (in_tag),
    .in_price       (in_price),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_head_tag   (out_head_tag),
    .out_head_price (out_head_price),
    .out_count      (out_count),
    .out_sum_total  (out_sum_total),
    .out_empty_res  (out_empty_res),
    .out_error      (out_error)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic queue_report_t apply_order(input logic func,
                                                input logic [TAG_BITS-1:0] tag,
                                                input logic [PRICE_BITS-1:0] price);
    queue_report_t r;
    int slot;
    logic [PRICE_BITS-1:0] gone;
    r = '0;
    r.error = ERR_NONE;
    if (func == FUNC_INSERT) begin
      if (held >= CAPACITY) begin
        r.error = ERR_FULL;
      end else begin
        slot = held;
        if (held == 0 || price < book[0].price) begin
          slot = 0;
        end else begin
          for (int i = 1; i < held; i++) begin
            if (book[i].price >= price) begin
              slot = i;
              break;
            end
          end
        end
        for (int i = held; i > slot; i--) book[i] = book[i-1];
        book[slot].tag = tag;
        book[slot].price = price;
        held++;
        book_sum = book_sum + SUM_BITS'(price);
      end
    end else begin
      if (held == 0) begin
        r.error = ERR_EMPTY;
      end else begin
        gone = book[0].price;
        for (int i = 0; i + 1 < held; i++) book[i] = book[i+1];
        held--;
        book_sum = book_sum - SUM_BITS'(gone);
      end
    end
    if (held > 0) begin
      r.head_tag = book[0].tag;
      r.head_price = book[0].price;
    end
    r.count = CNT_W'(held);
    r.sum_total = book_sum;
    r.empty_res = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    failures++;
    if (failures <= 50)
      $display("mismatch at %0t: %s want %0h got %0h", $time, what, want, got);
  endtask

  task automatic add_row(input logic func, input logic [TAG_BITS-1:0] tag,
                         input logic [PRICE_BITS-1:0] price, input bit typed,
                         input queue_report_t want);
    order_row_t row;
    row.func = func;
    row.tag = tag;
    row.price = price;
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // enter and leave at a falling edge
  task automatic drive_order(input logic func, input logic [TAG_BITS-1:0] tag,
                             input logic [PRICE_BITS-1:0] price, input bit typed,
                             input queue_report_t want);
    queue_report_t calc;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = func;
    in_tag = tag;
    in_price = price;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    calc = apply_order(func, tag, price);
    reports_due.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : watch_reports
    queue_report_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        report_mismatch("result with nothing due, count", 0, out_count);
      end else begin
        due = reports_due.pop_front();
        if (out_head_tag !== due.head_tag)
          report_mismatch("head_tag", due.head_tag, out_head_tag);
        if (out_head_price !== due.head_price)
          report_mismatch("head_price", due.head_price, out_head_price);
        if (out_count !== due.count)
          report_mismatch("count", due.count, out_count);
        if (out_sum_total !== due.sum_total)
          report_mismatch("sum_total", due.sum_total, out_sum_total);
        if (out_empty_res !== due.empty_res)
          report_mismatch("empty_res", due.empty_res, out_empty_res);
        if (out_error !== due.error)
          report_mismatch("error", due.error, out_error);
      end
    end
  end

  initial begin
    int insert_pct;
    logic func;
    logic [PRICE_BITS-1:0] price;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_INSERT;
    in_tag = '0;
    in_price = '0;
    gap_pct = 0;
    stall_pct = 0;
    failures = 0;
    held = 0;
    book_sum = '0;
    insert_pct = 50;

    // empty, extremes, equal head, equal tail, fill, full, drain
    add_row(FUNC_REMOVE, 16'h0, 20'h0, 1'b1,
            {16'h0, 20'h0, 5'd0, 24'h0, 1'b1, ERR_EMPTY});
    add_row(FUNC_INSERT, 16'hFFFF, 20'hFFFFF, 1'b1,
            {16'hFFFF, 20'hFFFFF, 5'd1, 24'h0FFFFF, 1'b0, ERR_NONE});
    add_row(FUNC_INSERT, 16'h0000, 20'h00000, 1'b0, '0);
    add_row(FUNC_INSERT, 16'h0001, 20'h00000, 1'b0, '0);
    add_row(FUNC_INSERT, 16'h0002, 20'hFFFFF, 1'b0, '0);
    for (int k = 0; k < 12; k++)
      add_row(FUNC_INSERT, 16'h5A00 + 16'(k), 20'(1000 * (k % 4) + (k % 3)), 1'b0, '0);
    add_row(FUNC_INSERT, 16'hAAAA, 20'h00005, 1'b0, '0);
    for (int k = 0; k < 4; k++)
      add_row(FUNC_REMOVE, 16'h5555, 20'hAAAAA, 1'b0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i])
      drive_order(plan[i].func, plan[i].tag, plan[i].price, plan[i].typed, plan[i].want);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 488; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(0, 3))
            0: insert_pct = 15;
            1: insert_pct = 50;
            2: insert_pct = 80;
            default: insert_pct = 100;
          endcase
        end
        func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: price = 20'($urandom_range(0, 7)) * 20'd125;
          5: price = $urandom_range(0, 1) ? '1 : '0;
          default: price = 20'($urandom);
        endcase
        drive_order(func, 16'($urandom), price, 1'b0, '0);
      end
      wait_drained();
    end

    if (failures == 0 && reports_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
